@@ rtl/crc32rc_pkg.sv @@
// crc32rc_pkg: shared types, constants and the byte update function
// for the reflected crc-32 block. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crc32rc_pkg;

    localparam logic [31:0] C_CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] C_START_DEFAULT = 32'hAA478422;

    // one input item as held in the input register
    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } t_in_item;

    // absorb one byte into a reflected crc register, eight shift-xor steps
    function automatic logic [31:0] crc_absorb_byte(input logic [31:0] crc,
                                                    input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/crc32_reflected_custom_init.sv @@
// crc32_reflected_custom_init: reflected crc-32 (poly edb88320, no final xor)
// the crc of a last byte passes the input register, then the result register; a stalled result holds it back
// throughput: one byte per cycle while the result register is not stalled
// reset: synchronous active low; start value returns to aa478422, no message open
// depends on crc32rc_pkg, crc32rc_in_stage, crc32rc_core
`timescale 1ns / 1ps
`default_nettype none

module crc32_reflected_custom_init
    import crc32rc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,      // start_value
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // [31:0] crc_value
);

    t_in_item w_in_item;
    t_in_item w_stage_item;
    logic     w_stage_valid;
    logic     w_advance;

    assign w_in_item.data_byte = i_s_axis_tdata;
    assign w_in_item.last_byte = i_s_axis_tlast;

    // input register
    crc32rc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // crc update and result register
    crc32rc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .o_advance   (w_advance),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_crc       (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/crc32rc_in_stage.sv @@
// crc32rc_in_stage: input register of the crc block
// depends on crc32rc_pkg for the item type
`timescale 1ns / 1ps
`default_nettype none

module crc32rc_in_stage
    import crc32rc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    // register is free when empty or when its item moves on this cycle
    assign o_ready = i_advance || !r_valid;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/crc32rc_core.sv @@
// crc32rc_core: start value register, running crc and result register
// depends on crc32rc_pkg for the item type and crc_absorb_byte
`timescale 1ns / 1ps
`default_nettype none

module crc32rc_core
    import crc32rc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    output logic             o_advance,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_crc
);

    logic [31:0] r_start;
    logic [31:0] r_crc;
    logic        r_in_msg;
    logic        r_out_valid;
    logic [31:0] r_out_crc;

    logic [31:0] w_base;
    logic [31:0] w_next;
    logic        w_take;

    // the pipeline moves whenever the result register can be loaded
    assign o_advance = i_out_ready || !r_out_valid;
    assign w_take    = o_advance && i_valid;

    // byte update from the running crc or, on a first byte, the start value
    assign w_base = r_in_msg ? r_crc : r_start;
    assign w_next = crc_absorb_byte(w_base, i_item.data_byte);

    // start value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= C_START_DEFAULT;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    // running crc and message flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= C_START_DEFAULT;
            r_in_msg <= 1'b0;
        end else if (w_take) begin
            if (i_item.last_byte) begin
                r_crc    <= r_start;
                r_in_msg <= 1'b0;
            end else begin
                r_crc    <= w_next;
                r_in_msg <= 1'b1;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid && i_item.last_byte;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last_byte) begin
            r_out_crc <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc       = r_out_crc;

endmodule

`default_nettype wire

@@ rtl/crc32rc_checker.sv @@
// crc32rc_checker: port-level checks on the crc block over time
// bound to crc32_reflected_custom_init, no package use
`timescale 1ns / 1ps
`default_nettype none

module crc32rc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        i_s_axis_tlast,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result dropped or changed while stalled");

    // a new result only follows an accepted last byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2))
        else $error("result without a last byte");

    // input side never waits while the result register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind crc32_reflected_custom_init crc32rc_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

@@ verif/tb_crc32_reflected_custom_init.sv @@
// tb_crc32_reflected_custom_init: self-checking bench for the reflected crc-32 block,
// byte stream in, one crc per message out, checked against an in-bench bit-serial model
// depends on crc32rc_pkg and crc32_reflected_custom_init
`timescale 1ns / 1ps

module tb_crc32_reflected_custom_init;
    import crc32rc_pkg::*;

    localparam logic [31:0] POLY_REFL    = 32'hEDB88320;
    localparam logic [31:0] START_AT_RST = 32'hAA478422;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 250;
    localparam int          CYCLE_LIMIT   = 600000;

    // crc bookkeeping: own copy of the start value and running register,
    // queue of crc values still owed by the block
    class crc_scoreboard;
        logic [31:0] start_value;
        logic [31:0] running_crc;
        bit          in_message;
        logic [31:0] pending_crcs[$];
        int          n_bytes;
        int          n_crcs;
        int          n_errors;

        function new();
            start_value = START_AT_RST;
            running_crc = START_AT_RST;
            in_message  = 1'b0;
            n_bytes     = 0;
            n_crcs      = 0;
            n_errors    = 0;
        endfunction

        function void set_start(input logic [31:0] value);
            start_value = value;
        endfunction

        // bit-serial form: data bits enter lsb first, feedback from bit 0
        function logic [31:0] shift_in_byte(input logic [31:0] crc, input logic [7:0] data);
            logic [31:0] c;
            logic        fb;
            c = crc;
            for (int b = 0; b < 8; b++) begin
                fb = c[0] ^ data[b];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ POLY_REFL;
                end
            end
            return c;
        endfunction

        // accepted input item
        function void note_byte(input logic [7:0] data, input logic last);
            logic [31:0] next_crc;
            next_crc = shift_in_byte(in_message ? running_crc : start_value, data);
            n_bytes++;
            if (last) begin
                pending_crcs.push_back(next_crc);
                running_crc = start_value;
                in_message  = 1'b0;
            end else begin
                running_crc = next_crc;
                in_message  = 1'b1;
            end
        endfunction

        // accepted result item
        function void check_crc(input logic [31:0] actual);
            logic [31:0] want;
            if (pending_crcs.size() == 0) begin
                $error("crc_value: unexpected result, expected none, actual %08h", actual);
                n_errors++;
            end else begin
                want = pending_crcs.pop_front();
                n_crcs++;
                if (actual !== want) begin
                    $error("crc_value mismatch: expected %08h, actual %08h", want, actual);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_wdata   = 32'd0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'd0;
    logic        s_tlast     = 1'b0;
    logic        m_tready    = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;

    crc_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;
    int  n_messages = 0;
    int  n_starts = 1;
    int  input_stall_cycles = 0;
    int  long_holds = 0;

    crc32_reflected_custom_init dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),   // start_value
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),     // [7:0] data_byte
        .i_s_axis_tlast  (s_tlast),     // last_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata) // [31:0] crc_value
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d crc values outstanding",
                     cycle_count, sb.pending_crcs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random back-pressure, or one long hold-off on request
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge i_clk);
            hold_req = 1'b0;
            long_holds++;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_crc(o_m_axis_tdata);
        end
    end

    // offer one byte, return at the falling edge after it was taken
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        sb.note_byte(data, last);
        @(negedge i_clk);
    endtask

    // message of random bytes, last flag on the final one
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(255)), k == len - 1);
        end
        n_messages++;
    endtask

    // wait until every crc is back and any open bytes have settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_crcs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_start(value);
        n_starts++;
    endtask

    // mostly short messages, now and then a long one
    task automatic run_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(48, 12) : $urandom_range(6, 1);
            send_message(len);
            sent += len;
        end
    endtask

    initial begin
        logic [7:0] check_str[9];
        sb = new();
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

        // reset
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: single-byte messages at the byte extremes, reset start value
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // walking ends of the byte in one message
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // start value written mid-message only counts from the next message
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        drain();
        write_start(32'h0000_0000);
        send_byte(8'h56, 1'b1);
        send_byte(8'hA5, 1'b1);
        drain();
        // all-ones start over the usual check string
        write_start(32'hFFFF_FFFF);
        foreach (check_str[k]) begin
            send_byte(check_str[k], k == 8);
        end
        send_byte(8'hFF, 1'b1);
        n_messages += 7;
        drain();

        // slow receiver
        write_start(32'($urandom));
        send_idle_pct = 24;
        recv_idle_pct = 84;
        run_random(600);
        drain();

        // slow sender
        write_start(32'hFFFF_FFFF);
        send_idle_pct = 84;
        recv_idle_pct = 24;
        run_random(600);
        drain();

        // full rate, starting with a long receiver hold-off to fill the block
        write_start(32'h0000_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (60) send_message($urandom_range(2, 1));
        run_random(250);
        drain();
        write_start(32'($urandom));
        run_random(250);
        drain();

        $display("covered %0d bytes in %0d messages under %0d start values, %0d crc values checked",
                 sb.n_bytes, n_messages, n_starts, sb.n_crcs);
        $display("input held back %0d cycles, %0d long output hold-off(s)",
                 input_stall_cycles, long_holds);
        if (sb.n_errors == 0 && sb.pending_crcs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/crc32rc_pkg.sv
rtl/crc32rc_in_stage.sv
rtl/crc32rc_core.sv
rtl/crc32_reflected_custom_init.sv
rtl/crc32rc_checker.sv
verif/tb_crc32_reflected_custom_init.sv
